@@ hdl/msr_pkg.sv @@
`timescale 1ns / 1ps

package msr_pkg;

	localparam int SPEED_W         = 16;
	localparam int STEP_W          = 15;
	localparam int PWM_W           = 8;
	localparam int FRAC_EXTRA      = 8;
	localparam int LEVEL_W         = SPEED_W + 1 + FRAC_EXTRA;
	localparam int MAX_STEPS       = 64;
	localparam int STEPS_W         = $clog2(MAX_STEPS + 1);
	localparam int DIV_W           = SPEED_W + FRAC_EXTRA;
	localparam int DIV_CNT_W       = $clog2(DIV_W + 1);
	localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 15'd1638;
	localparam logic [7:0]        FRAME_START     = 8'd36;

	typedef struct packed {
		logic signed [SPEED_W-1:0] src_left_speed;
		logic signed [SPEED_W-1:0] src_right_speed;
		logic signed [SPEED_W-1:0] dst_left_speed;
		logic signed [SPEED_W-1:0] dst_right_speed;
	} msr_in_t;

	typedef struct packed {
		logic [7:0]       frame_marker;
		logic             left_reverse;
		logic [PWM_W-1:0] left_pwm;
		logic             right_reverse;
		logic [PWM_W-1:0] right_pwm;
		logic             last_frame;
	} msr_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} msr_div_sts_t;

endpackage

@@ hdl/msr_div.sv @@
`timescale 1ns / 1ps

module msr_div import msr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_W-1:0]   dividend,
	input  logic [STEP_W-1:0]  divisor,
	output msr_div_sts_t       sts,
	output logic [DIV_W-1:0]   quotient
);

	logic [DIV_W-1:0]     dvd_q;
	logic [STEP_W-1:0]    dsr_q;
	logic [STEP_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W:0]      shifted;
	logic [STEP_W:0]      diff;
	logic                 ge;

	assign shifted = {rem_q, dvd_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end else if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dvd_q;

endmodule

@@ hdl/motor_speed_ramp_framer_core.sv @@
`timescale 1ns / 1ps
// Sequence: after the input transfer, three passes of one shared restoring divider, then
// the first frame is loaded into the output register once that register is free.
// A ramp with no step frees the input after the first divider pass.
// Throughput: one frame per cycle while out_ready is high, up to 64 frames; the next input
// transfer is taken only after the last frame of the ramp has been loaded.
// Reset: arst_n clears the sequencer, divider and output valid, and sets step_size to 1638.

module motor_speed_ramp_framer_core import msr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  msr_in_t           in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output msr_out_t          out_data,
	input  logic              cfg_we,
	input  logic [STEP_W-1:0] cfg_wdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIVN = 3'd1;
	localparam logic [2:0] ST_DIVL = 3'd2;
	localparam logic [2:0] ST_DIVR = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]          state_q;
	logic [STEP_W-1:0]   step_q;
	logic [LEVEL_W-1:0]  lvl_l_q, lvl_r_q, inc_l_q, inc_r_q;
	logic                lneg_q, rneg_q;
	logic [SPEED_W-1:0]  lmag_q, rmag_q;
	logic [STEPS_W-1:0]  n_q, cnt_q;
	logic                out_valid_q;
	msr_out_t            out_q;

	logic [SPEED_W:0]    ldiff, rdiff, lmag_w, rmag_w;
	logic [SPEED_W-1:0]  big;
	logic                div_start;
	logic [DIV_W-1:0]    div_dvd, div_q;
	logic [STEP_W-1:0]   div_dsr;
	msr_div_sts_t        div_sts;
	logic [STEPS_W-1:0]  n_sat;
	logic [LEVEL_W-1:0]  inc_w;
	logic                neg_sel;
	logic                out_free;

	function automatic logic [PWM_W:0] to_pwm(input logic [LEVEL_W-1:0] level);
		logic [LEVEL_W-1:0]  m;
		logic [LEVEL_W+7:0]  prod;
		logic [9:0]          p;
		m    = level[LEVEL_W-1] ? (LEVEL_W'(0) - level) : level;
		prod = {m, 8'h00} - {8'h00, m};
		p    = prod[LEVEL_W+7:LEVEL_W-2];
		to_pwm = {level[LEVEL_W-1], (p > 10'd255) ? 8'hFF : p[7:0]};
	endfunction

	msr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.sts      (div_sts),
		.quotient (div_q)
	);

	assign ldiff  = {in_data.dst_left_speed[SPEED_W-1], in_data.dst_left_speed}
		- {in_data.src_left_speed[SPEED_W-1], in_data.src_left_speed};
	assign rdiff  = {in_data.dst_right_speed[SPEED_W-1], in_data.dst_right_speed}
		- {in_data.src_right_speed[SPEED_W-1], in_data.src_right_speed};
	assign lmag_w = ldiff[SPEED_W] ? ((SPEED_W+1)'(0) - ldiff) : ldiff;
	assign rmag_w = rdiff[SPEED_W] ? ((SPEED_W+1)'(0) - rdiff) : rdiff;
	assign big    = (lmag_w[SPEED_W-1:0] < rmag_w[SPEED_W-1:0]) ?
		rmag_w[SPEED_W-1:0] : lmag_w[SPEED_W-1:0];

	assign n_sat   = (div_q > DIV_W'(MAX_STEPS)) ? STEPS_W'(MAX_STEPS) : div_q[STEPS_W-1:0];
	assign neg_sel = (state_q == ST_DIVL) ? lneg_q : rneg_q;
	assign inc_w   = neg_sel ? (LEVEL_W'(0) - {1'b0, div_q}) : {1'b0, div_q};

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		div_start = 1'b0;
		div_dvd   = {8'h00, big};
		div_dsr   = step_q;
		unique case (state_q)
			ST_IDLE: begin
				div_start = in_valid;
			end
			ST_DIVN: begin
				div_start = div_sts.done && (n_sat != '0);
				div_dvd   = {lmag_q, 8'h00};
				div_dsr   = {{(STEP_W-STEPS_W){1'b0}}, n_sat};
			end
			ST_DIVL: begin
				div_start = div_sts.done;
				div_dvd   = {rmag_q, 8'h00};
				div_dsr   = {{(STEP_W-STEPS_W){1'b0}}, n_q};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_SIZE_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				step_q <= cfg_wdata;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_DIVN;
				end
				ST_DIVN: begin
					if (div_sts.done) begin
						cnt_q   <= n_sat;
						state_q <= (n_sat == '0) ? ST_IDLE : ST_DIVL;
					end
				end
				ST_DIVL: begin
					if (div_sts.done)
						state_q <= ST_DIVR;
				end
				ST_DIVR: begin
					if (div_sts.done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cnt_q       <= cnt_q - 1'b1;
						if (cnt_q == STEPS_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			lvl_l_q <= {in_data.src_left_speed[SPEED_W-1], in_data.src_left_speed, 8'h00};
			lvl_r_q <= {in_data.src_right_speed[SPEED_W-1], in_data.src_right_speed, 8'h00};
			lneg_q  <= ldiff[SPEED_W];
			rneg_q  <= rdiff[SPEED_W];
			lmag_q  <= lmag_w[SPEED_W-1:0];
			rmag_q  <= rmag_w[SPEED_W-1:0];
		end
		if (state_q == ST_DIVN && div_sts.done)
			n_q <= n_sat;
		if (state_q == ST_DIVL && div_sts.done)
			inc_l_q <= inc_w;
		if (state_q == ST_DIVR && div_sts.done)
			inc_r_q <= inc_w;
		if (state_q == ST_EMIT && out_free) begin
			out_q.frame_marker                   <= FRAME_START;
			{out_q.left_reverse, out_q.left_pwm}   <= to_pwm(lvl_l_q);
			{out_q.right_reverse, out_q.right_pwm} <= to_pwm(lvl_r_q);
			out_q.last_frame                     <= (cnt_q == STEPS_W'(1));
			lvl_l_q <= lvl_l_q + inc_l_q;
			lvl_r_q <= lvl_r_q + inc_r_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hdl/msr_chk.sv @@
`timescale 1ns / 1ps

module msr_chk import msr_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input msr_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled output frame changed");

	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.frame_marker == FRAME_START)
		else $error("frame marker wrong");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an input transfer");

	a_ramp_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_frame |-> !in_ready)
		else $error("ready while a ramp still has frames");

endmodule

bind motor_speed_ramp_framer_core msr_chk u_msr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ tb/sv/tb_motor_speed_ramp_framer_core.sv @@
`timescale 1ns / 1ps

module tb_motor_speed_ramp_framer_core;
	import msr_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	msr_in_t           in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	msr_out_t          out_data;
	logic              cfg_we = 1'b0;
	logic [STEP_W-1:0] cfg_wdata = '0;

	msr_in_t  pending_cmds[$];
	msr_out_t frames_due[$];
	int       ramp_step = STEP_SIZE_RESET;
	int       bad_frames = 0;
	int       send_gap = 0;
	int       recv_gap = 0;
	int       recv_hold = 0;
	int       holds_asked = 0;
	int       holds_done = 0;
	bit       sender_calm = 1'b0;
	bit       receiver_calm = 1'b0;

	motor_speed_ramp_framer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [PWM_W-1:0] duty_of(int lev);
		longint m;
		longint p;
		m = (lev < 0) ? -longint'(lev) : longint'(lev);
		p = (m * 255) >>> 23;
		if (p > 255)
			p = 255;
		return PWM_W'(p);
	endfunction

	function automatic void predict_ramp(msr_in_t c);
		int sl, sr, dl, dr, ld, rd, lm, rm, big, n;
		int linc, rinc, llev, rlev;
		msr_out_t f;
		sl = int'(signed'(c.src_left_speed));
		sr = int'(signed'(c.src_right_speed));
		dl = int'(signed'(c.dst_left_speed));
		dr = int'(signed'(c.dst_right_speed));
		ld = dl - sl;
		rd = dr - sr;
		lm = (ld < 0) ? -ld : ld;
		rm = (rd < 0) ? -rd : rd;
		big = (lm < rm) ? rm : lm;
		n = (ramp_step == 0) ? MAX_STEPS : big / ramp_step;
		if (n > MAX_STEPS)
			n = MAX_STEPS;
		if (n == 0)
			return;
		linc = (ld * (1 << FRAC_EXTRA)) / n;
		rinc = (rd * (1 << FRAC_EXTRA)) / n;
		llev = sl * (1 << FRAC_EXTRA);
		rlev = sr * (1 << FRAC_EXTRA);
		for (int i = 0; i < n; i++) begin
			if (i != 0) begin
				llev += linc;
				rlev += rinc;
			end
			f.frame_marker  = FRAME_START;
			f.left_reverse  = (llev < 0);
			f.left_pwm      = duty_of(llev);
			f.right_reverse = (rlev < 0);
			f.right_pwm     = duty_of(rlev);
			f.last_frame    = (i + 1 == n);
			frames_due.push_back(f);
		end
	endfunction

	function automatic logic signed [SPEED_W-1:0] clamp_speed(int v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return SPEED_W'(v);
	endfunction

	function automatic logic signed [SPEED_W-1:0] pick_speed();
		case ($urandom_range(0, 5))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return '0;
			default: return SPEED_W'($urandom);
		endcase
	endfunction

	function automatic msr_in_t random_ramp();
		msr_in_t c;
		int unit, dlong, dshort;
		unit = (ramp_step == 0) ? 1024 : ramp_step;
		c.src_left_speed  = pick_speed();
		c.src_right_speed = pick_speed();
		if ($urandom_range(0, 3) == 0) begin
			c.dst_left_speed  = pick_speed();
			c.dst_right_speed = pick_speed();
		end else begin
			dlong = int'($urandom_range(0, 70)) * unit + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1))
				dlong = -dlong;
			dshort = int'($urandom_range(0, (dlong < 0) ? -dlong : dlong));
			if ($urandom_range(0, 1))
				dshort = -dshort;
			if ($urandom_range(0, 1)) begin
				c.dst_left_speed  = clamp_speed(int'(signed'(c.src_left_speed)) + dlong);
				c.dst_right_speed = clamp_speed(int'(signed'(c.src_right_speed)) + dshort);
			end else begin
				c.dst_left_speed  = clamp_speed(int'(signed'(c.src_left_speed)) + dshort);
				c.dst_right_speed = clamp_speed(int'(signed'(c.src_right_speed)) + dlong);
			end
		end
		return c;
	endfunction

	task automatic push_cmd(int sl, int sr, int dl, int dr);
		msr_in_t c;
		c.src_left_speed  = clamp_speed(sl);
		c.src_right_speed = clamp_speed(sr);
		c.dst_left_speed  = clamp_speed(dl);
		c.dst_right_speed = clamp_speed(dr);
		pending_cmds.push_back(c);
	endtask

	task automatic push_random(int count);
		repeat (count) pending_cmds.push_back(random_ramp());
	endtask

	task automatic write_step(logic [STEP_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		ramp_step = v;
		@(negedge clk);
	endtask

	task automatic drain_ramps();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || in_valid || frames_due.size() != 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			bad_frames++;
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_ramp(in_data);
				send_gap = sender_calm ? 0 : $urandom_range(0, 12);
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0 || pending_cmds.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					in_valid <= 1'b0;
				end else begin
					in_data  <= pending_cmds.pop_front();
					in_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		msr_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					bad_frames++;
					$display("%0t: frame with none due, expected nothing got %h",
						$time, out_data);
				end else begin
					want = frames_due.pop_front();
					check_field("frame_marker", want.frame_marker, out_data.frame_marker);
					check_field("left_reverse", 8'(want.left_reverse),
						8'(out_data.left_reverse));
					check_field("left_pwm", want.left_pwm, out_data.left_pwm);
					check_field("right_reverse", 8'(want.right_reverse),
						8'(out_data.right_reverse));
					check_field("right_pwm", want.right_pwm, out_data.right_pwm);
					check_field("last_frame", 8'(want.last_frame), 8'(out_data.last_frame));
				end
				recv_gap = receiver_calm ? 0 : $urandom_range(0, 12);
			end
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				recv_hold = 300;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb_motor_speed_ramp_framer_core NOT OK");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_cmd(-32768, -32768, 32767, 32767);
		push_cmd(32767, 32767, -32768, -32768);
		push_cmd(0, 0, 0, 0);
		push_cmd(0, 0, 1637, -1637);
		push_cmd(0, 0, 1638, 0);
		push_cmd(0, 0, -1638, 1639);
		push_cmd(-32768, 0, 32767, 100);
		push_cmd(100, 32767, -200, -32768);
		push_cmd(-1, 5, 3275, 5);
		push_cmd(-32768, 32767, -32768 + 3 * 1638, 32767 - 3 * 1638);
		push_cmd(16384, -16384, -16384, 16384);
		push_cmd(-300, -1, -300, -1);
		push_cmd(-128, 127, 30000, -30000);
		push_cmd(21845, -21846, -21846, 21845);
		push_cmd(-5, -1, -5, 6552);
		drain_ramps();

		write_step('0);
		push_cmd(0, 0, 0, 0);
		push_cmd(-1, -1, -1, -1);
		push_random(5);
		drain_ramps();

		write_step(15'h7FFF);
		push_cmd(-32768, 32767, 32767, -32768);
		push_cmd(0, 0, 32766, 0);
		push_random(58);
		drain_ramps();

		write_step(15'd1);
		push_cmd(3, 3, 3, 3);
		push_cmd(-32768, -32768, 32767, 32767);
		push_random(5);
		drain_ramps();

		// hold the output so the core fills and stalls its input
		write_step(15'd1024);
		sender_calm = 1'b1;
		holds_asked++;
		push_random(12);
		drain_ramps();
		receiver_calm = 1'b1;
		push_random(60);
		drain_ramps();

		repeat (4) begin
			write_step(STEP_W'($urandom_range(1024, 32767)));
			sender_calm   = ($urandom_range(0, 3) == 0);
			receiver_calm = ($urandom_range(0, 3) == 0);
			push_random(60);
			drain_ramps();
		end

		write_step(STEP_SIZE_RESET);
		sender_calm   = 1'b0;
		receiver_calm = 1'b0;
		push_random(60);
		drain_ramps();

		if (frames_due.size() != 0)
			bad_frames++;
		if (bad_frames == 0)
			$display("tb_motor_speed_ramp_framer_core OK");
		else
			$display("tb_motor_speed_ramp_framer_core NOT OK");
		$finish;
	end

endmodule
